>>> sv/xoro_pkg.sv
// ----------------------------------------------------------------------------
// xoro_pkg
// Shared types and constants of the xoroshiro128+ generator core.
// ----------------------------------------------------------------------------
package xoro_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] JUMP_MASK_0 = 64'hBEAC_0467_EBA5_FACB;
    localparam logic [WORD_W-1:0] JUMP_MASK_1 = 64'hD86B_048B_86AA_9922;

    // Jump mask bits in the order they are consumed: mask 0 first, bit 0 first.
    localparam logic [2*WORD_W-1:0] JUMP_BITS = {JUMP_MASK_1, JUMP_MASK_0};
    localparam int JUMP_STEPS = 2 * WORD_W;
    localparam int JCNT_W     = $clog2(JUMP_STEPS);

    localparam int ROT_A       = 55;
    localparam int SHIFT_B     = 14;
    localparam int ROT_C       = 36;
    localparam int MIX_SHIFT_A = 30;
    localparam int MIX_SHIFT_B = 27;

    // Mix sequence: six partial products, then one more step to fold in the last.
    localparam int MIX_STEPS = 6;
    localparam int MSTEP_W   = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_JUMP,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic draw;   // take a draw transaction: register the sum, advance
        logic seed;   // take a seed transaction: latch mixed operands
        logic mix;    // one multiply/accumulate step
        logic jump;   // one jump step
        logic load;   // copy jump accumulators into the state words
    } t_cmd;

    typedef struct packed {
        logic mix_last;
        logic jump_last;
    } t_stat;

endpackage

>>> sv/xoro_ctrl.sv
// ----------------------------------------------------------------------------
// xoro_ctrl
// Sequencer for draw and seed transactions and the output register handshake.
// ----------------------------------------------------------------------------
module xoro_ctrl
    import xoro_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_mode,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_mode) begin
                    n_state = ST_MIX;
                end
            end
            ST_MIX: begin
                if (i_stat.mix_last) begin
                    n_state = ST_JUMP;
                end
            end
            ST_JUMP: begin
                if (i_stat.jump_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_cmd.draw = w_accept && !i_in_mode;
                o_cmd.seed = w_accept && i_in_mode;
                if (w_accept && !i_in_mode) begin
                    n_out_valid = 1'b1;
                end
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
            end
            ST_JUMP: begin
                o_cmd.jump = 1'b1;
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> sv/xoro_dpath.sv
// ----------------------------------------------------------------------------
// xoro_dpath
// State words, output register, seed mixer on a shared 32x32 multiplier,
// and the jump accumulators.
// ----------------------------------------------------------------------------
module xoro_dpath
    import xoro_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [WORD_W-1:0] i_seed,
    output logic [WORD_W-1:0] o_random,
    output t_stat             o_stat
);

    logic [WORD_W-1:0]  r_word_a;
    logic [WORD_W-1:0]  r_word_b;
    logic [WORD_W-1:0]  n_word_a;
    logic [WORD_W-1:0]  n_word_b;
    logic [WORD_W-1:0]  r_acc_a;
    logic [WORD_W-1:0]  r_acc_b;
    logic [WORD_W-1:0]  r_x_a;
    logic [WORD_W-1:0]  r_x_b;
    logic [WORD_W-1:0]  r_prod;
    logic [WORD_W-1:0]  r_random;
    logic [MSTEP_W-1:0] r_mstep;
    logic [JCNT_W-1:0]  r_jcnt;

    logic [WORD_W-1:0]  w_t;
    logic [WORD_W-1:0]  w_adv_a;
    logic [WORD_W-1:0]  w_adv_b;
    logic [HALF_W-1:0]  w_op_x;
    logic [HALF_W-1:0]  w_op_k;
    logic [WORD_W-1:0]  w_high_add;

    // xoroshiro128+ step
    assign w_t     = r_word_a ^ r_word_b;
    assign w_adv_a = ((r_word_a << ROT_A) | (r_word_a >> (WORD_W - ROT_A)))
                     ^ w_t ^ (w_t << SHIFT_B);
    assign w_adv_b = (w_t << ROT_C) | (w_t >> (WORD_W - ROT_C));

    // 64x64 product mod 2^64 = xl*kl + ((xl*kh + xh*kl) << 32)
    always_comb begin
        case (r_mstep)
            3'd0:    begin w_op_x = r_x_a[HALF_W-1:0];      w_op_k = MIX_MUL_A[HALF_W-1:0];      end
            3'd1:    begin w_op_x = r_x_a[HALF_W-1:0];      w_op_k = MIX_MUL_A[WORD_W-1:HALF_W]; end
            3'd2:    begin w_op_x = r_x_a[WORD_W-1:HALF_W]; w_op_k = MIX_MUL_A[HALF_W-1:0];      end
            3'd3:    begin w_op_x = r_x_b[HALF_W-1:0];      w_op_k = MIX_MUL_B[HALF_W-1:0];      end
            3'd4:    begin w_op_x = r_x_b[HALF_W-1:0];      w_op_k = MIX_MUL_B[WORD_W-1:HALF_W]; end
            3'd5:    begin w_op_x = r_x_b[WORD_W-1:HALF_W]; w_op_k = MIX_MUL_B[HALF_W-1:0];      end
            default: begin w_op_x = '0;                     w_op_k = '0;                         end
        endcase
    end

    assign w_high_add = {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb begin
        n_word_a = r_word_a;
        n_word_b = r_word_b;
        if (i_cmd.draw || i_cmd.jump) begin
            n_word_a = w_adv_a;
            n_word_b = w_adv_b;
        end else if (i_cmd.mix) begin
            // fold in the product registered on the previous step
            case (r_mstep)
                3'd1:        n_word_a = r_prod;
                3'd2, 3'd3:  n_word_a = r_word_a + w_high_add;
                3'd4:        n_word_b = r_prod;
                3'd5, 3'd6:  n_word_b = r_word_b + w_high_add;
                default:     n_word_a = r_word_a;
            endcase
        end else if (i_cmd.load) begin
            n_word_a = r_acc_a;
            n_word_b = r_acc_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_a <= '0;
            r_word_b <= '0;
            r_mstep  <= '0;
            r_jcnt   <= '0;
        end else begin
            r_word_a <= n_word_a;
            r_word_b <= n_word_b;
            if (i_cmd.seed) begin
                r_mstep <= '0;
                r_jcnt  <= '0;
            end else begin
                if (i_cmd.mix) begin
                    r_mstep <= r_mstep + 1'b1;
                end
                if (i_cmd.jump) begin
                    r_jcnt <= r_jcnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw) begin
            r_random <= r_word_a + r_word_b;
        end
        if (i_cmd.seed) begin
            r_x_a   <= i_seed ^ (i_seed >> MIX_SHIFT_A);
            r_x_b   <= i_seed ^ (i_seed >> MIX_SHIFT_B);
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (i_cmd.jump && JUMP_BITS[r_jcnt]) begin
            r_acc_a <= r_acc_a ^ r_word_a;
            r_acc_b <= r_acc_b ^ r_word_b;
        end
        if (i_cmd.mix) begin
            r_prod <= WORD_W'(w_op_x) * WORD_W'(w_op_k);
        end
    end

    assign o_random         = r_random;
    assign o_stat.mix_last  = (r_mstep == MSTEP_W'(MIX_STEPS));
    assign o_stat.jump_last = (r_jcnt == JCNT_W'(JUMP_STEPS - 1));

endmodule

>>> sv/xoroshiro128_plus_prng_core.sv
// ----------------------------------------------------------------------------
// xoroshiro128_plus_prng_core
// xoroshiro128+ generator with a seed-and-jump command on a stream interface.
// ----------------------------------------------------------------------------
// A draw transaction (tuser = 0) moves the sum of the two state words into
// the output register and advances the words, so draws stream at one per
// clock while the output side keeps up. A seed transaction (tuser = 1, seed
// in tdata) produces no output, and the input side is held off until it is
// done: the mixed seed is latched, the two 64-bit multiplies are done as
// three partial products each on one 32x32 multiplier, 128 jump steps run
// (one per mask bit), and the jumped state is loaded.
// After reset the state is all zero and draws return zero until seeded.
// ----------------------------------------------------------------------------
module xoroshiro128_plus_prng_core
    import xoro_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [63:0] seed_value
    input  logic              s_axis_tuser,   // [0] mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata    // [63:0] random_value
);

    t_cmd  w_cmd;
    t_stat w_stat;

    xoro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    xoro_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_seed   (s_axis_tdata),
        .o_random (m_axis_tdata),
        .o_stat   (w_stat)
    );

endmodule

>>> tb/xoro_tb_pkg.sv
// ----------------------------------------------------------------------------
// xoro_tb_pkg
// Testbench-side codes for the xoroshiro128+ generator core.
// ----------------------------------------------------------------------------
package xoro_tb_pkg;

    // Meaning of the input tuser bit.
    typedef enum logic {
        MODE_DRAW = 1'b0,
        MODE_SEED = 1'b1
    } t_mode;

endpackage

>>> tb/xoro_stream_checker.sv
// ----------------------------------------------------------------------------
// xoro_stream_checker
// Watches both stream channels of the generator core, tracks the generator
// state on every accepted input transaction and compares each output
// transaction against the oldest predicted sum.
// ----------------------------------------------------------------------------
module xoro_stream_checker
    import xoro_pkg::*, xoro_tb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [WORD_W-1:0] i_in_data,
    input  logic              i_in_mode,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [WORD_W-1:0] i_out_data,
    output int                o_mismatches,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_W-1:0] gen_a = '0;
    logic [WORD_W-1:0] gen_b = '0;
    logic [WORD_W-1:0] sums_due[$];
    logic [WORD_W-1:0] want;
    int                errs = 0;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic void step_words(inout logic [WORD_W-1:0] a, inout logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] t;
        t = a ^ b;
        a = rotl(a, ROT_A) ^ t ^ (t << SHIFT_B);
        b = rotl(t, ROT_C);
    endfunction

    // Mix the seed into both words, then jump ahead by 2^64 draws.
    function automatic void seed_and_jump(input  logic [WORD_W-1:0] seed,
                                          output logic [WORD_W-1:0] a,
                                          output logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] acc_a;
        logic [WORD_W-1:0] acc_b;
        a = (seed ^ (seed >> MIX_SHIFT_A)) * MIX_MUL_A;
        b = (seed ^ (seed >> MIX_SHIFT_B)) * MIX_MUL_B;
        acc_a = '0;
        acc_b = '0;
        for (int k = 0; k < JUMP_STEPS; k++) begin
            if (JUMP_BITS[k]) begin
                acc_a ^= a;
                acc_b ^= b;
            end
            step_words(a, b);
        end
        a = acc_a;
        b = acc_b;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gen_a = '0;
            gen_b = '0;
            sums_due.delete();
        end else begin
            // Check the output first: a sum accepted now came from an earlier draw.
            if (i_out_valid && i_out_ready) begin
                if (sums_due.size() == 0) begin
                    $display("%0t: random_value expected none, actual %h", $time, i_out_data);
                    errs++;
                end else begin
                    want = sums_due.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: random_value expected %h, actual %h",
                                 $time, want, i_out_data);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_mode == MODE_SEED) begin
                    seed_and_jump(i_in_data, gen_a, gen_b);
                end else begin
                    sums_due.push_back(gen_a + gen_b);
                    step_words(gen_a, gen_b);
                end
            end
        end
        o_pending    <= sums_due.size();
        o_mismatches <= errs;
    end

endmodule

>>> tb/tb_xoroshiro128_plus_prng_core.sv
// ----------------------------------------------------------------------------
// tb_xoroshiro128_plus_prng_core
// Stream testbench for the xoroshiro128+ generator core.
// ----------------------------------------------------------------------------
// Drives a directed opening (draws from the zero state, seed zero, all-ones
// and single-bit seeds, back-to-back seeds) and then about a thousand random
// transactions, mostly draws with an occasional reseed. Both sides insert
// random gaps with calm stretches, and the output side holds off once for a
// long stretch so the core backs up its input. A checker beside the core
// predicts every sum and reports mismatches.
// ----------------------------------------------------------------------------
module tb_xoroshiro128_plus_prng_core
    import xoro_pkg::*, xoro_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1030;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 200;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata;   // [63:0] seed_value
    logic              s_axis_tuser;   // [0] mode
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [WORD_W-1:0] m_axis_tdata;   // [63:0] random_value
    int                mismatches;
    int                pending;
    int                send_calm = 0;
    int                recv_calm = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    xoroshiro128_plus_prng_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xoro_stream_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_mode    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Offer one transaction after a random gap and wait for it to be taken.
    task automatic offer(input t_mode mode, input logic [WORD_W-1:0] data);
        int gap;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 29) == 0)
                send_calm = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Draws carry random tdata: the core must ignore it.
    task automatic draws(input int n);
        repeat (n) offer(MODE_DRAW, {$urandom, $urandom});
    endtask

    initial begin
        logic [WORD_W-1:0] seed;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_DRAW;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero state straight out of reset.
        offer(MODE_DRAW, '1);
        draws(1);
        // Seed zero keeps the state at zero.
        offer(MODE_SEED, '0);
        draws(2);
        offer(MODE_SEED, '1);
        draws(3);
        offer(MODE_SEED, 64'd1);
        draws(2);
        offer(MODE_SEED, 64'h8000_0000_0000_0000);
        draws(1);
        offer(MODE_SEED, 64'hAAAA_AAAA_AAAA_AAAA);
        draws(1);
        offer(MODE_SEED, 64'h5555_5555_5555_5555);
        draws(1);
        // Reseed right after a seed: only the last one counts.
        offer(MODE_SEED, 64'h0000_0000_FFFF_FFFF);
        offer(MODE_SEED, 64'hFFFF_FFFF_0000_0000);
        draws(2);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if ($urandom_range(0, 32) == 0) begin
                case ($urandom_range(0, 9))
                    0:       seed = '0;
                    1:       seed = '1;
                    default: seed = {$urandom, $urandom};
                endcase
                offer(MODE_SEED, seed);
            end else begin
                draws(1);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        // Let a trailing seed finish and any stray output show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Output side: random stalls, calm stretches and one long hold-off.
    initial begin
        int hold;
        int taken;
        taken = 0;
        m_axis_tready <= 1'b0;
        forever begin
            if (taken == 100) begin
                hold = LONG_HOLD;
            end else if (recv_calm > 0) begin
                hold = 0;
                recv_calm--;
            end else begin
                hold = $urandom_range(0, 4);
                if ($urandom_range(0, 29) == 0)
                    recv_calm = $urandom_range(20, 60);
            end
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    initial begin
        #500_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
